FILE: design/swie_pkg.sv
// shared constants, types and result codes for the shallow water eigensystem core
package swie_pkg;

   // number format
   localparam int FRAC_BITS = 16;
   localparam int DATA_W    = 32;
   localparam int GRAV_W    = 31;
   localparam logic [GRAV_W-1:0] GRAVITY_RESET = GRAV_W'(642908);

   // divider operands: magnitudes of 33-bit sums, dividend scaled by 2^FRAC_BITS
   localparam int DEN_W = DATA_W + 1;
   localparam int NUM_W = DATA_W + 1 + FRAC_BITS;

   // square root: 64-bit radicand, one root bit per stage
   localparam int ROOT_W = DATA_W;
   localparam int RAD_W  = 2 * ROOT_W;

   // both arithmetic units: one input stage plus one stage per quotient or root bit
   localparam int UNIT_LAT   = DATA_W + 1;
   localparam int PIPE_DEPTH = 2 * UNIT_LAT + 3;

   localparam logic signed [DATA_W-1:0] SAT_MAX = {1'b0, {(DATA_W-1){1'b1}}};
   localparam logic signed [DATA_W-1:0] SAT_MIN = {1'b1, {(DATA_W-1){1'b0}}};

   typedef enum logic [1:0] {
      LOC_LEFT  = 2'd0,
      LOC_RIGHT = 2'd1,
      LOC_IFACE = 2'd2
   } loc_type;

   typedef struct packed {
      logic [NUM_W-1:0] num;
      logic [DEN_W-1:0] den;
      logic             neg;
   } div_in_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] minus;
      logic signed [DATA_W-1:0] mid;
      logic signed [DATA_W-1:0] plus;
   } eig_type;

   typedef struct packed {
      eig_type                  left;
      eig_type                  right;
      eig_type                  iface;
      logic signed [DATA_W-1:0] l10;
      logic                     ok_l;
      logic                     ok_r;
      logic                     ok_s;
   } side_type;

   typedef struct packed {
      eig_type                  left;
      eig_type                  right;
      eig_type                  iface;
      logic signed [DATA_W-1:0] l00;
      logic signed [DATA_W-1:0] l01;
      logic signed [DATA_W-1:0] l10;
      logic signed [DATA_W-1:0] l20;
      logic                     ok_l;
      logic                     ok_r;
      logic                     ok_s;
   } item_type;

endpackage

FILE: design/swie_div.sv
// pipelined restoring divider, one quotient bit per stage, saturating signed result
module swie_div import swie_pkg::*; (
   input  logic                     clock,
   input  logic                     en,
   input  div_in_type               div_in,
   output logic signed [DATA_W-1:0] quo
);

   localparam int STEPS = DATA_W;
   localparam int REM_W = DEN_W + 1;
   localparam int HI_W  = NUM_W - DATA_W;

   logic [REM_W-1:0]  rem_ff  [STEPS+1];
   logic [DATA_W-1:0] low_ff  [STEPS+1];
   logic [DATA_W-1:0] q_ff    [STEPS+1];
   logic [DEN_W-1:0]  den_ff  [STEPS+1];
   logic              neg_ff  [STEPS+1];
   logic              zero_ff [STEPS+1];
   logic              ovf_ff  [STEPS+1];

   logic [DEN_W-1:0] hi_in;
   logic             ovf_in;
   logic [DATA_W-1:0] q_last;

   // upper dividend bits decide overflow of the 32-bit quotient up front
   assign hi_in  = DEN_W'(div_in.num[NUM_W-1 -: HI_W]);
   assign ovf_in = (hi_in >= div_in.den);

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff[0]  <= ovf_in ? '0 : REM_W'(hi_in);
         low_ff[0]  <= div_in.num[DATA_W-1:0];
         q_ff[0]    <= '0;
         den_ff[0]  <= div_in.den;
         neg_ff[0]  <= div_in.neg;
         zero_ff[0] <= (div_in.den == '0);
         ovf_ff[0]  <= ovf_in;
      end
   end

   // one shift, compare and subtract per stage
   for (genvar k = 1; k <= STEPS; k++) begin : g_step
      localparam int B = STEPS - k;
      logic [REM_W-1:0] trial;
      logic             ge;

      always_comb begin
         trial = {rem_ff[k-1][REM_W-2:0], low_ff[k-1][B]};
         ge    = (trial >= {1'b0, den_ff[k-1]});
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k]  <= ge ? (trial - {1'b0, den_ff[k-1]}) : trial;
            low_ff[k]  <= low_ff[k-1];
            q_ff[k]    <= q_ff[k-1] | (DATA_W'(ge) << B);
            den_ff[k]  <= den_ff[k-1];
            neg_ff[k]  <= neg_ff[k-1];
            zero_ff[k] <= zero_ff[k-1];
            ovf_ff[k]  <= ovf_ff[k-1];
         end
      end
   end

   // sign and saturation
   assign q_last = q_ff[STEPS];

   always_comb begin
      if (zero_ff[STEPS]) begin
         quo = '0;
      end else if (neg_ff[STEPS]) begin
         if (ovf_ff[STEPS] || (q_last[DATA_W-1] && (|q_last[DATA_W-2:0]))) begin
            quo = SAT_MIN;
         end else begin
            quo = $signed(DATA_W'(~q_last + DATA_W'(1)));
         end
      end else begin
         if (ovf_ff[STEPS] || q_last[DATA_W-1]) begin
            quo = SAT_MAX;
         end else begin
            quo = $signed(q_last);
         end
      end
   end

endmodule

FILE: design/swie_sqrt.sv
// pipelined integer square root, one root bit per stage
module swie_sqrt import swie_pkg::*; (
   input  logic              clock,
   input  logic              en,
   input  logic [RAD_W-1:0]  radicand,
   output logic [ROOT_W-1:0] root
);

   localparam int STEPS  = ROOT_W;
   localparam int SREM_W = ROOT_W + 3;

   logic [RAD_W-1:0]  rad_ff  [STEPS+1];
   logic [SREM_W-1:0] rem_ff  [STEPS+1];
   logic [ROOT_W-1:0] root_ff [STEPS+1];

   always_ff @(posedge clock) begin
      if (en) begin
         rad_ff[0]  <= radicand;
         rem_ff[0]  <= '0;
         root_ff[0] <= '0;
      end
   end

   // bring down two radicand bits, try root*4+1
   for (genvar k = 1; k <= STEPS; k++) begin : g_step
      localparam int TOP = RAD_W - 1 - 2 * (k - 1);
      logic [SREM_W-1:0] trial;
      logic [SREM_W-1:0] test;
      logic              ge;

      always_comb begin
         trial = {rem_ff[k-1][SREM_W-3:0], rad_ff[k-1][TOP -: 2]};
         test  = {1'b0, root_ff[k-1], 2'b01};
         ge    = (trial >= test);
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rad_ff[k]  <= rad_ff[k-1];
            rem_ff[k]  <= ge ? (trial - test) : trial;
            root_ff[k] <= {root_ff[k-1][ROOT_W-2:0], ge};
         end
      end
   end

   assign root = root_ff[STEPS];

endmodule

FILE: design/swie_ser.sv
// result sequencer: holds one finished cell pair and hands out its three results
module swie_ser import swie_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     in_valid,
   input  item_type                 in_item,
   output logic                     take,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic [1:0]               rsp_location,
   output logic signed [DATA_W-1:0] rsp_lambda_minus,
   output logic signed [DATA_W-1:0] rsp_lambda_mid,
   output logic signed [DATA_W-1:0] rsp_lambda_plus,
   output logic signed [DATA_W-1:0] rsp_lrow0_col0,
   output logic signed [DATA_W-1:0] rsp_lrow0_col1,
   output logic signed [DATA_W-1:0] rsp_lrow1_col0,
   output logic signed [DATA_W-1:0] rsp_lrow2_col0,
   output logic                     rsp_well_defined,
   output logic                     rsp_last
);

   logic     valid_ff, valid_in;
   loc_type  idx_ff, idx_in;
   item_type item_ff;
   eig_type  cur;
   logic     is_iface;

   // free to load once empty or once the interface result leaves
   assign take = !valid_ff || (!rsp_stall && (idx_ff == LOC_IFACE));

   always_comb begin
      valid_in = valid_ff;
      idx_in   = idx_ff;
      if (take) begin
         valid_in = in_valid;
         idx_in   = LOC_LEFT;
      end else if (!rsp_stall) begin
         unique case (idx_ff)
            LOC_LEFT:  idx_in = LOC_RIGHT;
            LOC_RIGHT: idx_in = LOC_IFACE;
            default:   idx_in = LOC_LEFT;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= LOC_LEFT;
      end else begin
         valid_ff <= valid_in;
         idx_ff   <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take && in_valid) begin
         item_ff <= in_item;
      end
   end

   // pick the result for the current location
   always_comb begin
      unique case (idx_ff)
         LOC_LEFT: begin
            cur              = item_ff.left;
            rsp_well_defined = item_ff.ok_l;
         end
         LOC_RIGHT: begin
            cur              = item_ff.right;
            rsp_well_defined = item_ff.ok_r;
         end
         default: begin
            cur              = item_ff.iface;
            rsp_well_defined = item_ff.ok_s;
         end
      endcase
   end

   assign is_iface         = (idx_ff == LOC_IFACE);
   assign rsp_valid        = valid_ff;
   assign rsp_location     = idx_ff;
   assign rsp_lambda_minus = cur.minus;
   assign rsp_lambda_mid   = cur.mid;
   assign rsp_lambda_plus  = cur.plus;
   assign rsp_lrow0_col0   = is_iface ? item_ff.l00 : '0;
   assign rsp_lrow0_col1   = is_iface ? item_ff.l01 : '0;
   assign rsp_lrow1_col0   = is_iface ? item_ff.l10 : '0;
   assign rsp_lrow2_col0   = is_iface ? item_ff.l20 : '0;
   assign rsp_last         = is_iface;

   // a run starts over at the left cell after its interface result
   a_run_restart: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall && rsp_last) |=> (!rsp_valid || rsp_location == LOC_LEFT))
      else $error("run did not restart at the left cell");

   // a run is never cut short
   a_run_whole: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall && !rsp_last) |=> rsp_valid)
      else $error("run ended before its interface result");

   // once a depth is bad the flag stays low for the rest of the run
   a_flag_sticky: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall && !rsp_last && !rsp_well_defined) |=> !rsp_well_defined)
      else $error("well defined flag came back within a run");

endmodule

FILE: design/shallow_water_interface_eigensystem_core.sv
// top level: shallow water x-flux eigensystem of one cell interface
//
// A request carries two adjacent cells (depth, x momentum, y momentum, Q16.16).
// Each request yields three results on the rsp channel: eigenvalues of the left
// cell, of the right cell, then of the averaged interface with the left
// eigenvector entries; rsp_last marks the interface result.
// Both channels move a request or result at an edge with valid high and stall low.
// Gravity is written through csr_wr_en / csr_wr_data while the block is idle; the
// user is bound to this, the block itself does not enforce it. A taken request
// passes stages 1 and 2, the velocity dividers and square roots, the eigen stage,
// the eigenvector dividers and the sequencer before its first result shows; the
// other two follow in turn while rsp_stall stays low. The three results share the
// single result port; while req_stall is low the compute pipeline moves one request
// per cycle through velocity dividers and square roots, then eigenvector dividers,
// each 33 stages deep. Reset (synchronous) empties the pipeline and loads the default
// gravity. When rsp_stall is high the current result holds; the pipeline keeps filling
// bubbles until a finished request waits at its end, then req_stall rises.
module shallow_water_interface_eigensystem_core import swie_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic signed [DATA_W-1:0] req_left_depth,
   input  logic signed [DATA_W-1:0] req_left_mom_x,
   input  logic signed [DATA_W-1:0] req_left_mom_y,
   input  logic signed [DATA_W-1:0] req_right_depth,
   input  logic signed [DATA_W-1:0] req_right_mom_x,
   input  logic signed [DATA_W-1:0] req_right_mom_y,
   input  logic                     csr_wr_en,
   input  logic [GRAV_W-1:0]        csr_wr_data,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic [1:0]               rsp_location,
   output logic signed [DATA_W-1:0] rsp_lambda_minus,
   output logic signed [DATA_W-1:0] rsp_lambda_mid,
   output logic signed [DATA_W-1:0] rsp_lambda_plus,
   output logic signed [DATA_W-1:0] rsp_lrow0_col0,
   output logic signed [DATA_W-1:0] rsp_lrow0_col1,
   output logic signed [DATA_W-1:0] rsp_lrow1_col0,
   output logic signed [DATA_W-1:0] rsp_lrow2_col0,
   output logic                     rsp_well_defined,
   output logic                     rsp_last
);

   localparam int END_IDX = PIPE_DEPTH - 1;

   // saturate a 34-bit signed value to 32 bits
   function automatic logic signed [DATA_W-1:0] sat_wide(input logic signed [DATA_W+1:0] x);
      logic signed [DATA_W+1:0] hi_lim;
      logic signed [DATA_W+1:0] lo_lim;
      hi_lim = $signed({2'b00, SAT_MAX});
      lo_lim = $signed({2'b11, SAT_MIN});
      if (x > hi_lim) begin
         return SAT_MAX;
      end else if (x < lo_lim) begin
         return SAT_MIN;
      end
      return x[DATA_W-1:0];
   endfunction

   // magnitudes and sign of value * 2^F / divisor
   function automatic div_in_type make_div(input logic signed [DEN_W-1:0] value,
                                           input logic signed [DEN_W-1:0] divisor,
                                           input logic flip);
      div_in_type d;
      logic [DEN_W-1:0] mag;
      mag   = value[DEN_W-1] ? unsigned'(-value) : unsigned'(value);
      d.num = NUM_W'(mag) << FRAC_BITS;
      d.den = divisor[DEN_W-1] ? unsigned'(-divisor) : unsigned'(divisor);
      d.neg = value[DEN_W-1] ^ divisor[DEN_W-1] ^ flip;
      return d;
   endfunction

   // u - c, u, u + c
   function automatic eig_type make_eig(input logic signed [DATA_W-1:0] u,
                                        input logic [ROOT_W-1:0] c);
      eig_type e;
      logic signed [DATA_W+1:0] uw;
      logic signed [DATA_W+1:0] cw;
      uw      = (DATA_W+2)'(u);
      cw      = $signed({2'b00, c});
      e.minus = sat_wide(uw - cw);
      e.mid   = u;
      e.plus  = sat_wide(uw + cw);
      return e;
   endfunction

   logic              go;
   logic              take;
   logic              valid_ff [PIPE_DEPTH];
   logic [GRAV_W-1:0] gravity_ff;

   // gravity register
   always_ff @(posedge clock) begin
      if (reset) begin
         gravity_ff <= GRAVITY_RESET;
      end else if (csr_wr_en) begin
         gravity_ff <= csr_wr_data;
      end
   end

   // whole pipeline moves unless a finished request waits at its end
   assign go        = !valid_ff[END_IDX] || take;
   assign req_stall = !go;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < PIPE_DEPTH; i++) begin
            valid_ff[i] <= 1'b0;
         end
      end else if (go) begin
         valid_ff[0] <= req_valid;
         for (int i = 1; i < PIPE_DEPTH; i++) begin
            valid_ff[i] <= valid_ff[i-1];
         end
      end
   end

   // stage 1: capture request, form interface sums
   logic signed [DEN_W-1:0] hl_ff, mxl_ff, hr_ff, mxr_ff, hs_ff, mxs_ff, mys_ff;
   logic [GRAV_W-1:0]       g1_ff;

   always_ff @(posedge clock) begin
      if (go) begin
         hl_ff  <= DEN_W'(req_left_depth);
         mxl_ff <= DEN_W'(req_left_mom_x);
         hr_ff  <= DEN_W'(req_right_depth);
         mxr_ff <= DEN_W'(req_right_mom_x);
         hs_ff  <= DEN_W'(req_left_depth) + DEN_W'(req_right_depth);
         mxs_ff <= DEN_W'(req_left_mom_x) + DEN_W'(req_right_mom_x);
         mys_ff <= DEN_W'(req_left_mom_y) + DEN_W'(req_right_mom_y);
         g1_ff  <= gravity_ff;
      end
   end

   // stage 2: g*h products and divider operands
   logic                       pos_l, pos_r, pos_s;
   logic [2*GRAV_W-1:0]        prod_l, prod_r;
   logic [GRAV_W+DATA_W-1:0]   prod_s;
   div_in_type                 dul_ff, dur_ff, dus_ff, dvs_ff;
   logic [RAD_W-1:0]           radl_ff, radr_ff, rads_ff;
   logic [2:0]                 ok2_ff;

   assign pos_l  = !hl_ff[DEN_W-1] && (hl_ff != '0);
   assign pos_r  = !hr_ff[DEN_W-1] && (hr_ff != '0);
   assign pos_s  = !hs_ff[DEN_W-1] && (hs_ff != '0);
   assign prod_l = g1_ff * hl_ff[GRAV_W-1:0];
   assign prod_r = g1_ff * hr_ff[GRAV_W-1:0];
   assign prod_s = g1_ff * hs_ff[DATA_W-1:0];

   always_ff @(posedge clock) begin
      if (go) begin
         dul_ff  <= make_div(mxl_ff, hl_ff, 1'b0);
         dur_ff  <= make_div(mxr_ff, hr_ff, 1'b0);
         dus_ff  <= make_div(mxs_ff, hs_ff, 1'b0);
         dvs_ff  <= make_div(mys_ff, hs_ff, 1'b1);
         radl_ff <= pos_l ? RAD_W'(prod_l) : '0;
         radr_ff <= pos_r ? RAD_W'(prod_r) : '0;
         rads_ff <= pos_s ? RAD_W'(prod_s >> 1) : '0;
         ok2_ff  <= {pos_l, pos_l & pos_r, pos_l & pos_r & pos_s};
      end
   end

   // velocities and celerities
   logic signed [DATA_W-1:0] u_l, u_r, u_s, nv_s;
   logic [ROOT_W-1:0]        c_l, c_r, c_s;

   swie_div u_div_ul (.clock(clock), .en(go), .div_in(dul_ff), .quo(u_l));
   swie_div u_div_ur (.clock(clock), .en(go), .div_in(dur_ff), .quo(u_r));
   swie_div u_div_us (.clock(clock), .en(go), .div_in(dus_ff), .quo(u_s));
   swie_div u_div_vs (.clock(clock), .en(go), .div_in(dvs_ff), .quo(nv_s));

   swie_sqrt u_sqrt_l (.clock(clock), .en(go), .radicand(radl_ff), .root(c_l));
   swie_sqrt u_sqrt_r (.clock(clock), .en(go), .radicand(radr_ff), .root(c_r));
   swie_sqrt u_sqrt_s (.clock(clock), .en(go), .radicand(rads_ff), .root(c_s));

   // flags travel beside the first unit stage
   logic [2:0] ok_line_ff [UNIT_LAT];

   always_ff @(posedge clock) begin
      if (go) begin
         ok_line_ff[0] <= ok2_ff;
         for (int i = 1; i < UNIT_LAT; i++) begin
            ok_line_ff[i] <= ok_line_ff[i-1];
         end
      end
   end

   // eigen stage: eigenvalues and eigenvector divider operands
   logic signed [DEN_W-1:0] u33, c33, twoc, upc, cmu;
   div_in_type              d01;
   side_type                se_ff;
   div_in_type              d00_ff, d01_ff, d20_ff;

   assign u33      = DEN_W'(u_s);
   assign c33      = $signed({1'b0, c_s});
   assign twoc     = $signed({c_s, 1'b0});
   assign upc      = u33 + c33;
   assign cmu      = c33 - u33;
   assign d01.num  = NUM_W'(1) << (2 * FRAC_BITS - 1);
   assign d01.den  = {1'b0, c_s};
   assign d01.neg  = 1'b1;

   always_ff @(posedge clock) begin
      if (go) begin
         se_ff.left  <= make_eig(u_l, c_l);
         se_ff.right <= make_eig(u_r, c_r);
         se_ff.iface <= make_eig(u_s, c_s);
         se_ff.l10   <= nv_s;
         se_ff.ok_l  <= ok_line_ff[UNIT_LAT-1][2];
         se_ff.ok_r  <= ok_line_ff[UNIT_LAT-1][1];
         se_ff.ok_s  <= ok_line_ff[UNIT_LAT-1][0];
         d00_ff      <= make_div(upc, twoc, 1'b0);
         d20_ff      <= make_div(cmu, twoc, 1'b0);
         d01_ff      <= d01;
      end
   end

   // left eigenvector entries
   logic signed [DATA_W-1:0] l00, l01, l20;

   swie_div u_div_l00 (.clock(clock), .en(go), .div_in(d00_ff), .quo(l00));
   swie_div u_div_l01 (.clock(clock), .en(go), .div_in(d01_ff), .quo(l01));
   swie_div u_div_l20 (.clock(clock), .en(go), .div_in(d20_ff), .quo(l20));

   side_type side_line_ff [UNIT_LAT];

   always_ff @(posedge clock) begin
      if (go) begin
         side_line_ff[0] <= se_ff;
         for (int i = 1; i < UNIT_LAT; i++) begin
            side_line_ff[i] <= side_line_ff[i-1];
         end
      end
   end

   // finished request
   item_type end_item;
   side_type end_side;

   assign end_side       = side_line_ff[UNIT_LAT-1];
   assign end_item.left  = end_side.left;
   assign end_item.right = end_side.right;
   assign end_item.iface = end_side.iface;
   assign end_item.l00   = l00;
   assign end_item.l01   = l01;
   assign end_item.l10   = end_side.l10;
   assign end_item.l20   = l20;
   assign end_item.ok_l  = end_side.ok_l;
   assign end_item.ok_r  = end_side.ok_r;
   assign end_item.ok_s  = end_side.ok_s;

   swie_ser u_ser (
      .clock            (clock),
      .reset            (reset),
      .in_valid         (valid_ff[END_IDX]),
      .in_item          (end_item),
      .take             (take),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_location     (rsp_location),
      .rsp_lambda_minus (rsp_lambda_minus),
      .rsp_lambda_mid   (rsp_lambda_mid),
      .rsp_lambda_plus  (rsp_lambda_plus),
      .rsp_lrow0_col0   (rsp_lrow0_col0),
      .rsp_lrow0_col1   (rsp_lrow0_col1),
      .rsp_lrow1_col0   (rsp_lrow1_col0),
      .rsp_lrow2_col0   (rsp_lrow2_col0),
      .rsp_well_defined (rsp_well_defined),
      .rsp_last         (rsp_last)
   );

   // an accepted request enters the first stage
   a_req_enters: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> valid_ff[0])
      else $error("accepted request missing from first stage");

endmodule

FILE: sim/testbench.sv
// testbench for the shallow water interface eigensystem core
module testbench;
   import swie_pkg::*;

   localparam int LIMIT_CYCLES = 400000;
   localparam int N_RANDOM     = 100;
   localparam int N_DIRECTED   = 14;

   typedef struct {
      logic [1:0]         loc;
      logic signed [31:0] lm, lu, lp, l00, l01, l10, l20;
      logic               ok, last;
   } eigen_result_type;

   typedef struct {
      logic signed [31:0] hl, mxl, myl, hr, mxr, myr;
      logic               known;
      logic signed [31:0] lm_left;
   } pair_row_type;

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0;
   logic req_stall;
   logic signed [31:0] req_left_depth = 0, req_left_mom_x = 0, req_left_mom_y = 0;
   logic signed [31:0] req_right_depth = 0, req_right_mom_x = 0, req_right_mom_y = 0;
   logic csr_wr_en = 0;
   logic [GRAV_W-1:0] csr_wr_data = 0;
   logic rsp_valid;
   logic rsp_stall = 0;
   logic [1:0] rsp_location;
   logic signed [31:0] rsp_lambda_minus, rsp_lambda_mid, rsp_lambda_plus;
   logic signed [31:0] rsp_lrow0_col0, rsp_lrow0_col1, rsp_lrow1_col0, rsp_lrow2_col0;
   logic rsp_well_defined, rsp_last;

   shallow_water_interface_eigensystem_core uut (.*);

   initial begin
      forever #5 clock = ~clock;
   end

   // predictor state and store of pending eigen results
   logic [63:0] gravity_model = 64'(GRAVITY_RESET);
   eigen_result_type pending_eigen[$];
   int mismatches = 0;
   int cycles = 0;
   bit stim_done = 0;

   function automatic longint sat(longint x);
      if (x > 64'sd2147483647) return 64'sd2147483647;
      if (x < -64'sd2147483648) return -64'sd2147483648;
      return x;
   endfunction

   function automatic longint int_sqrt(logic [63:0] x);
      logic [63:0] r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > x) b >>= 2;
      while (b != 0) begin
         if (x >= r + b) begin
            x = x - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b >>= 2;
      end
      return longint'(r);
   endfunction

   function automatic longint cell_speed(longint m, longint d);
      if (d == 0) return 0;
      return (m * (64'sd1 <<< FRAC_BITS)) / d;
   endfunction

   function automatic eigen_result_type make_eigen(logic [1:0] loc, longint u, longint c,
         longint a00, longint a01, longint a10, longint a20, bit ok, bit last);
      eigen_result_type r;
      r.loc = loc;
      r.lm = 32'(sat(u - c));
      r.lu = 32'(u);
      r.lp = 32'(sat(u + c));
      r.l00 = 32'(a00);
      r.l01 = 32'(a01);
      r.l10 = 32'(a10);
      r.l20 = 32'(a20);
      r.ok = ok;
      r.last = last;
      return r;
   endfunction

   // expected results of one cell pair
   task automatic predict_eigensystem(pair_row_type p);
      longint hl, hr, hs, u, c, v, a00, a01, a20;
      bit ok;
      hl = p.hl;
      hr = p.hr;
      ok = 1;
      a00 = 0;
      a01 = 0;
      a20 = 0;
      // left cell
      u = sat(cell_speed(p.mxl, hl));
      c = (hl > 0) ? int_sqrt(gravity_model * 64'(hl)) : 0;
      if (hl <= 0) ok = 0;
      pending_eigen.push_back(make_eigen(LOC_LEFT, u, c, 0, 0, 0, 0, ok, 0));
      // right cell
      u = sat(cell_speed(p.mxr, hr));
      c = (hr > 0) ? int_sqrt(gravity_model * 64'(hr)) : 0;
      if (hr <= 0) ok = 0;
      pending_eigen.push_back(make_eigen(LOC_RIGHT, u, c, 0, 0, 0, 0, ok, 0));
      // interface from summed cells
      hs = hl + hr;
      u = sat(cell_speed(longint'(p.mxl) + p.mxr, hs));
      v = cell_speed(longint'(p.myl) + p.myr, hs);
      c = (hs > 0) ? int_sqrt((gravity_model * 64'(hs)) >> 1) : 0;
      if (hs <= 0) ok = 0;
      if (c > 0) begin
         a00 = sat(((u + c) * (64'sd1 <<< FRAC_BITS)) / (2 * c));
         a20 = sat(((c - u) * (64'sd1 <<< FRAC_BITS)) / (2 * c));
         a01 = sat(-((64'sd1 <<< (2 * FRAC_BITS - 1)) / c));
      end
      pending_eigen.push_back(make_eigen(LOC_IFACE, u, c, a00, a01, sat(-v), a20, ok, 1));
   endtask

   // directed table: extremes, zero and negative depths
   pair_row_type directed[N_DIRECTED];
   initial begin
      directed[0]  = '{32'sh10000, 0, 0, 32'sh10000, 0, 0, 0, 0};
      directed[1]  = '{0, 32'sh10000, 32'sh10000, 0, 32'sh7fffffff, 1, 1, 0};
      directed[2]  = '{-32'sh10000, 5, 6, -32'sh20000, 7, 8, 0, 0};
      directed[3]  = '{32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff,
                       32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 0, 0};
      directed[4]  = '{32'sh80000000, 32'sh80000000, 32'sh80000000,
                       32'sh80000000, 32'sh80000000, 32'sh80000000, 0, 0};
      directed[5]  = '{1, 32'sh7fffffff, 32'sh80000000, 1, 32'sh80000000, 32'sh7fffffff, 0, 0};
      directed[6]  = '{32'sh10000, 32'sh10000, 0, -32'sh10000, 0, 0, 0, 0};
      directed[7]  = '{32'sh20000, -32'sh30000, 32'sh4000, 32'sh8000, 32'sh1234, -5, 0, 0};
      directed[8]  = '{32'shffffffff, 3, 3, 1, 3, 3, 0, 0};
      directed[9]  = '{32'sh7fffffff, 0, 0, 1, 0, 0, 0, 0};
      directed[10] = '{32'sh5555, 32'shaaaa, 32'sh5555aaaa, 32'sh2aaaa, 32'shd5555555, 1, 0, 0};
      directed[11] = '{1, 1, 1, 1, 1, 1, 0, 0};
      directed[12] = '{32'sh40000000, 32'sh7fff0000, -32'sh7fff0000, 32'sh3fffffff, 9, 9, 0, 0};
      directed[13] = '{32'sh1000, -32'sh1, 32'sh1, 32'sh1000, 32'sh1, -32'sh1, 0, 0};
   end

   // one request through the handshake, valid stays high for a back to back follower
   task automatic send_pair(pair_row_type p);
      int gap;
      gap = $urandom_range(0, 13);
      if ($urandom_range(0, 3) == 0) gap = 0;
      if (gap > 0) begin
         req_valid <= 0;
         repeat (gap) @(negedge clock);
      end
      req_left_depth <= p.hl;
      req_left_mom_x <= p.mxl;
      req_left_mom_y <= p.myl;
      req_right_depth <= p.hr;
      req_right_mom_x <= p.mxr;
      req_right_mom_y <= p.myr;
      req_valid <= 1;
      predict_eigensystem(p);
      if (p.known && pending_eigen[$-2].lm != p.lm_left) begin
         mismatches++;
         if (mismatches <= 10)
            $display("directed row lambda_minus exp %0d got %0d",
                     p.lm_left, pending_eigen[$-2].lm);
      end
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
   endtask

   function automatic logic signed [31:0] rand_depth();
      case ($urandom_range(0, 9))
         0: return 0;
         1: return -$signed(32'($urandom_range(1, 32'h7fffff)));
         2: return 32'($urandom);
         3: return 32'h7fffffff - 32'($urandom_range(0, 3));
         default: return 32'($urandom_range(1, 32'h00ffffff));
      endcase
   endfunction

   function automatic logic signed [31:0] rand_mom();
      case ($urandom_range(0, 5))
         0: return 32'($urandom);
         1: return ($urandom_range(0, 1)) ? 32'sh7fffffff : 32'sh80000000;
         default: return $signed(32'($urandom_range(0, 32'h01ffffff))) - 32'sh00ffffff;
      endcase
   endfunction

   // wait for the block to drain before a gravity write
   task automatic write_gravity(logic [GRAV_W-1:0] g);
      req_valid <= 0;
      while (pending_eigen.size() != 0) @(negedge clock);
      repeat (80) @(negedge clock);
      csr_wr_en <= 1;
      csr_wr_data <= g;
      @(negedge clock);
      csr_wr_en <= 0;
      gravity_model = 64'(g);
   endtask

   // stimulus
   initial begin
      pair_row_type p;
      logic [GRAV_W-1:0] g;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 0;
      directed[0].known = 1;
      directed[0].lm_left = -32'(int_sqrt(64'd642908 << 16));
      for (int i = 0; i < N_DIRECTED; i++) send_pair(directed[i]);
      write_gravity('0);
      send_pair(pair_row_type'{32'sh10000, 32'sh10000, 1, 1, 2, 3, 0, 0});
      write_gravity({GRAV_W{1'b1}});
      for (int i = 0; i < 6; i++) send_pair(directed[i + 3]);
      for (int ph = 0; ph < 4; ph++) begin
         case (ph)
            0: g = 31'(642908);
            1: g = 31'($urandom);
            2: g = 31'($urandom_range(1, 32'h100000));
            default: g = 1;
         endcase
         write_gravity(g);
         for (int i = 0; i < N_RANDOM / 4; i++) begin
            p.hl = rand_depth();
            p.hr = rand_depth();
            p.mxl = rand_mom();
            p.myl = rand_mom();
            p.mxr = rand_mom();
            p.myr = rand_mom();
            p.known = 0;
            p.lm_left = 0;
            send_pair(p);
         end
      end
      req_valid <= 0;
      stim_done = 1;
   end

   // result stall pattern
   initial begin
      int hold;
      forever begin
         @(negedge clock);
         if ($urandom_range(0, 2) == 0) begin
            hold = $urandom_range(0, 13);
            if (hold > 0) begin
               rsp_stall <= 1;
               repeat (hold) @(negedge clock);
               rsp_stall <= 0;
            end
         end else begin
            repeat ($urandom_range(0, 13)) @(negedge clock);
         end
      end
   end

   // result checker
   always @(posedge clock) begin
      eigen_result_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_eigen.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result at location %0d", rsp_location);
         end else begin
            e = pending_eigen.pop_front();
            if (e.loc !== rsp_location || e.lm !== rsp_lambda_minus
                || e.lu !== rsp_lambda_mid || e.lp !== rsp_lambda_plus
                || e.l00 !== rsp_lrow0_col0 || e.l01 !== rsp_lrow0_col1
                || e.l10 !== rsp_lrow1_col0 || e.l20 !== rsp_lrow2_col0
                || e.ok !== rsp_well_defined || e.last !== rsp_last) begin
               mismatches++;
               if (mismatches <= 10) begin
                  $display("mismatch exp loc %0d lam %0d %0d %0d l %0d %0d %0d %0d ok %0d last %0d",
                           e.loc, e.lm, e.lu, e.lp, e.l00, e.l01, e.l10, e.l20, e.ok, e.last);
                  $display("         got loc %0d lam %0d %0d %0d l %0d %0d %0d %0d ok %0d last %0d",
                           rsp_location, rsp_lambda_minus, rsp_lambda_mid, rsp_lambda_plus,
                           rsp_lrow0_col0, rsp_lrow0_col1, rsp_lrow1_col0, rsp_lrow2_col0,
                           rsp_well_defined, rsp_last);
               end
            end
         end
      end
   end

   // end of run and timeout
   initial begin
      forever begin
         @(posedge clock);
         cycles++;
         if (cycles > LIMIT_CYCLES) begin
            $display("shallow_water_interface_eigensystem_core verification failed");
            $finish;
         end
         if (stim_done && pending_eigen.size() == 0) begin
            repeat (100) @(posedge clock);
            if (mismatches == 0 && pending_eigen.size() == 0)
               $display("shallow_water_interface_eigensystem_core verification clean");
            else
               $display("shallow_water_interface_eigensystem_core verification failed");
            $finish;
         end
      end
   end
endmodule

FILE: sim.f
design/swie_pkg.sv
design/swie_div.sv
design/swie_sqrt.sv
design/swie_ser.sv
design/shallow_water_interface_eigensystem_core.sv
sim/testbench.sv
